[rtl/core/gmdfs_pkg.sv]
package gmdfs_pkg;

    // grid geometry
    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int POS_W      = ROW_W + COL_W;
    localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;

    // counters must hold CELL_TOTAL itself
    localparam int CNT_W      = $clog2(CELL_TOTAL) + 1;

    // stack entry: cell position and last tried direction
    localparam int DIR_W      = 2;
    localparam int ENTRY_W    = POS_W + DIR_W;

    // register and field widths
    localparam int CNT_REG_W  = 6;
    localparam int START_W    = 5;
    localparam int CELL_W     = 2;
    localparam int APB_DW     = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;
    localparam int IN_DW      = 16;
    localparam int OUT_DW     = 40;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_OPEN = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL = 2'd1;
    localparam logic [CELL_W-1:0] CELL_DEST = 2'd2;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_ROW = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_COL = 2'd3;

    // neighbor order
    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN,
        DIR_RIGHT,
        DIR_UP,
        DIR_LEFT
    } dir_t;

endpackage

[rtl/core/gmdfs_ram.sv]
module gmdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/grid_maze_depth_first_search.sv]
// Load beats: one per cycle while no search is running, no result beat.
// Search beat: visited-map clear; if the start cell lies in the grid, a start step, then per
// neighbor a skip outside the grid or a check in the grid/visited memories, a stack pop per
// exhausted cell, and the result post, held while the previous result beat waits.
// Reset (aresetn low, synchronous): registers to 32/32/0/0, then a pass clears the grid
// to open; no input beat is taken during that pass.
module grid_maze_depth_first_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gmdfs_pkg::IN_DW-1:0]         s_tdata,  // cell_row, cell_col, cell_kind
    input  logic                                s_tuser,  // kind
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gmdfs_pkg::OUT_DW-1:0]        m_tdata,  // found, end_row, end_col,
                                                          // path_length, visited_count
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gmdfs_pkg::PADDR_W-1:0]       paddr,
    input  logic [gmdfs_pkg::APB_DW-1:0]        pwdata,
    output logic [gmdfs_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VCLR,
        ST_INIT,
        ST_STEP,
        ST_CHECK,
        ST_POP,
        ST_DONE
    } state_t;

    localparam int POS_W = gmdfs_pkg::POS_W;
    localparam int CNT_W = gmdfs_pkg::CNT_W;
    localparam int RC_W  = gmdfs_pkg::CNT_REG_W;

    // configuration registers
    logic [RC_W-1:0]                   row_count_reg;
    logic [RC_W-1:0]                   col_count_reg;
    logic [gmdfs_pkg::START_W-1:0]     start_row_reg;
    logic [gmdfs_pkg::START_W-1:0]     start_col_reg;
    logic [gmdfs_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gmdfs_pkg::REG_IDX_W+1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= RC_W'(gmdfs_pkg::MAX_ROWS);
            col_count_reg <= RC_W'(gmdfs_pkg::MAX_COLS);
            start_row_reg <= '0;
            start_col_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                gmdfs_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[RC_W-1:0];
                gmdfs_pkg::REG_COL_COUNT: col_count_reg <= pwdata[RC_W-1:0];
                gmdfs_pkg::REG_START_ROW: start_row_reg <= pwdata[gmdfs_pkg::START_W-1:0];
                gmdfs_pkg::REG_START_COL: start_col_reg <= pwdata[gmdfs_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            gmdfs_pkg::REG_ROW_COUNT: prdata = gmdfs_pkg::APB_DW'(row_count_reg);
            gmdfs_pkg::REG_COL_COUNT: prdata = gmdfs_pkg::APB_DW'(col_count_reg);
            gmdfs_pkg::REG_START_ROW: prdata = gmdfs_pkg::APB_DW'(start_row_reg);
            gmdfs_pkg::REG_START_COL: prdata = gmdfs_pkg::APB_DW'(start_col_reg);
            default:                  prdata = '0;
        endcase
    end

    // search limits, counts clamped to the store size
    logic [RC_W-1:0]  rows_lim;
    logic [RC_W-1:0]  cols_lim;
    logic             start_in;
    logic [POS_W-1:0] start_pos;

    assign rows_lim  = (row_count_reg > RC_W'(gmdfs_pkg::MAX_ROWS)) ?
                       RC_W'(gmdfs_pkg::MAX_ROWS) : row_count_reg;
    assign cols_lim  = (col_count_reg > RC_W'(gmdfs_pkg::MAX_COLS)) ?
                       RC_W'(gmdfs_pkg::MAX_COLS) : col_count_reg;
    assign start_in  = (RC_W'(start_row_reg) < rows_lim) && (RC_W'(start_col_reg) < cols_lim);
    assign start_pos = {start_row_reg[gmdfs_pkg::ROW_W-1:0], start_col_reg[gmdfs_pkg::COL_W-1:0]};

    // control and datapath registers
    state_t                          state_reg,   state_next;
    logic [POS_W-1:0]                clr_reg,     clr_next;
    logic [CNT_W-1:0]                depth_reg,   depth_next;
    logic [CNT_W-1:0]                vcount_reg,  vcount_next;
    logic                            found_reg,   found_next;
    logic [POS_W-1:0]                top_pos_reg, top_pos_next;
    logic [gmdfs_pkg::DIR_W:0]       top_dir_reg, top_dir_next;
    logic [gmdfs_pkg::DIR_W-1:0]     try_dir_reg, try_dir_next;
    logic [POS_W-1:0]                np_reg,      np_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [gmdfs_pkg::OUT_DW-1:0]    out_reg,     out_next;

    // memory ports
    logic                            grid_we;
    logic [POS_W-1:0]                grid_waddr;
    logic [gmdfs_pkg::CELL_W-1:0]    grid_wdata;
    logic [gmdfs_pkg::CELL_W-1:0]    grid_rdata;
    logic                            vis_we;
    logic [POS_W-1:0]                vis_waddr;
    logic                            vis_wdata;
    logic                            vis_rdata;
    logic                            stk_we;
    logic [POS_W-1:0]                stk_waddr;
    logic [POS_W-1:0]                stk_raddr;
    logic [gmdfs_pkg::ENTRY_W-1:0]   stk_wdata;
    logic [gmdfs_pkg::ENTRY_W-1:0]   stk_rdata;

    // neighbor of the top cell in the current direction
    logic [gmdfs_pkg::ROW_W-1:0]     top_r;
    logic [gmdfs_pkg::COL_W-1:0]     top_c;
    logic [RC_W-1:0]                 nb_r;
    logic [RC_W-1:0]                 nb_c;
    logic                            nb_ok;
    logic [POS_W-1:0]                nb_pos;
    logic [CNT_W-1:0]                depth_m1;
    logic [CNT_W-1:0]                depth_m2;

    assign top_r = top_pos_reg[POS_W-1:gmdfs_pkg::COL_W];
    assign top_c = top_pos_reg[gmdfs_pkg::COL_W-1:0];

    always_comb begin
        nb_r  = RC_W'(top_r);
        nb_c  = RC_W'(top_c);
        nb_ok = 1'b0;
        case (gmdfs_pkg::dir_t'(top_dir_reg[gmdfs_pkg::DIR_W-1:0]))
            gmdfs_pkg::DIR_DOWN: begin
                nb_r  = RC_W'(top_r) + RC_W'(1);
                nb_ok = nb_r < rows_lim;
            end
            gmdfs_pkg::DIR_RIGHT: begin
                nb_c  = RC_W'(top_c) + RC_W'(1);
                nb_ok = nb_c < cols_lim;
            end
            gmdfs_pkg::DIR_UP: begin
                nb_r  = RC_W'(top_r) - RC_W'(1);
                nb_ok = top_r != '0;
            end
            gmdfs_pkg::DIR_LEFT: begin
                nb_c  = RC_W'(top_c) - RC_W'(1);
                nb_ok = top_c != '0;
            end
            default: nb_ok = 1'b0;
        endcase
    end

    assign nb_pos    = {nb_r[gmdfs_pkg::ROW_W-1:0], nb_c[gmdfs_pkg::COL_W-1:0]};
    assign depth_m1  = depth_reg - CNT_W'(1);
    assign depth_m2  = depth_reg - CNT_W'(2);
    assign stk_raddr = depth_m2[POS_W-1:0];

    logic blocked;
    logic is_dest;

    assign blocked = vis_rdata || ((np_reg != start_pos) && (grid_rdata == gmdfs_pkg::CELL_WALL));
    assign is_dest = (np_reg != start_pos) && (grid_rdata == gmdfs_pkg::CELL_DEST);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // sequencer: clear, load, search walk, result
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        depth_next    = depth_reg;
        vcount_next   = vcount_reg;
        found_next    = found_reg;
        top_pos_next  = top_pos_reg;
        top_dir_next  = top_dir_reg;
        try_dir_next  = try_dir_reg;
        np_next       = np_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        grid_we    = 1'b0;
        grid_waddr = clr_reg;
        grid_wdata = gmdfs_pkg::CELL_OPEN;
        vis_we     = 1'b0;
        vis_waddr  = clr_reg;
        vis_wdata  = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = depth_m1[POS_W-1:0];
        stk_wdata  = {top_pos_reg, try_dir_reg};

        case (state_reg)
            ST_CLEAR: begin
                grid_we  = 1'b1;
                vis_we   = 1'b1;
                clr_next = clr_reg + POS_W'(1);
                if (clr_reg == POS_W'(gmdfs_pkg::CELL_TOTAL - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == gmdfs_pkg::KIND_SEARCH) begin
                        clr_next    = '0;
                        depth_next  = '0;
                        vcount_next = '0;
                        found_next  = 1'b0;
                        state_next  = ST_VCLR;
                    end else begin
                        grid_we    = 1'b1;
                        grid_waddr = {s_tdata[gmdfs_pkg::ROW_W-1:0],
                                      s_tdata[5+gmdfs_pkg::COL_W-1:5]};
                        grid_wdata = s_tdata[11:10];
                    end
                end
            end
            ST_VCLR: begin
                vis_we   = 1'b1;
                clr_next = clr_reg + POS_W'(1);
                if (clr_reg == POS_W'(gmdfs_pkg::CELL_TOTAL - 1)) begin
                    state_next = start_in ? ST_INIT : ST_DONE;
                end
            end
            ST_INIT: begin
                vis_we       = 1'b1;
                vis_waddr    = start_pos;
                vis_wdata    = 1'b1;
                vcount_next  = CNT_W'(1);
                depth_next   = CNT_W'(1);
                top_pos_next = start_pos;
                top_dir_next = '0;
                state_next   = ST_STEP;
            end
            ST_STEP: begin
                if (top_dir_reg[gmdfs_pkg::DIR_W]) begin
                    // all four directions tried: pop
                    depth_next = depth_m1;
                    state_next = (depth_reg == CNT_W'(1)) ? ST_DONE : ST_POP;
                end else begin
                    try_dir_next = top_dir_reg[gmdfs_pkg::DIR_W-1:0];
                    top_dir_next = top_dir_reg + 3'd1;
                    if (nb_ok) begin
                        np_next    = nb_pos;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                state_next = ST_STEP;
                if (!blocked) begin
                    vis_we       = 1'b1;
                    vis_waddr    = np_reg;
                    vis_wdata    = 1'b1;
                    vcount_next  = vcount_reg + CNT_W'(1);
                    stk_we       = 1'b1;
                    top_pos_next = np_reg;
                    top_dir_next = '0;
                    depth_next   = depth_reg + CNT_W'(1);
                    if (is_dest) begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_POP: begin
                top_pos_next = stk_rdata[gmdfs_pkg::ENTRY_W-1:gmdfs_pkg::DIR_W];
                top_dir_next = {1'b0, stk_rdata[gmdfs_pkg::DIR_W-1:0]} + 3'd1;
                state_next   = ST_STEP;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next = '0;
                    out_next[0]     = found_reg;
                    out_next[5:1]   = found_reg ? top_r : start_row_reg;
                    out_next[10:6]  = found_reg ? top_c : start_col_reg;
                    out_next[21:11] = found_reg ? depth_reg : '0;
                    out_next[32:22] = vcount_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            depth_reg    <= '0;
            vcount_reg   <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            depth_reg    <= depth_next;
            vcount_reg   <= vcount_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            top_pos_reg  <= top_pos_next;
            top_dir_reg  <= top_dir_next;
            try_dir_reg  <= try_dir_next;
            np_reg       <= np_next;
            out_reg      <= out_next;
        end
    end

    // grid store, read at the neighbor cell
    gmdfs_ram #(
        .WIDTH(gmdfs_pkg::CELL_W),
        .DEPTH(gmdfs_pkg::CELL_TOTAL)
    ) u_grid (
        .aclk (aclk),
        .we   (grid_we),
        .waddr(grid_waddr),
        .wdata(grid_wdata),
        .raddr(nb_pos),
        .rdata(grid_rdata)
    );

    // visited map
    gmdfs_ram #(
        .WIDTH(1),
        .DEPTH(gmdfs_pkg::CELL_TOTAL)
    ) u_visited (
        .aclk (aclk),
        .we   (vis_we),
        .waddr(vis_waddr),
        .wdata(vis_wdata),
        .raddr(nb_pos),
        .rdata(vis_rdata)
    );

    // entries below the top of stack
    gmdfs_ram #(
        .WIDTH(gmdfs_pkg::ENTRY_W),
        .DEPTH(gmdfs_pkg::CELL_TOTAL)
    ) u_stack (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // checks
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(gmdfs_pkg::CELL_TOTAL))
        else $error("stack depth above cell count");

    a_stack_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= vcount_reg)
        else $error("more cells on stack than visited");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat not from done state");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_reg[0]) |->
        (out_reg[21:11] != '0) && (out_reg[21:11] <= out_reg[32:22]))
        else $error("found result with bad path length");

endmodule
